/* rtl/trsc_pkg.sv */
package trsc_pkg;

   // Default geometry
   localparam int RING_BYTES_DEF = 32768;
   localparam int MAX_CHUNK_DEF  = 2048;

   // Field widths
   localparam int TYPE_W   = 4;
   localparam int PLEN_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 15;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 15;
   localparam int CLEN_W   = 15;
   localparam int DROP_W   = 32;
   localparam int TICKS_W  = 8;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Request codes
   localparam logic [TYPE_W-1:0] REQ_PKT_START  = 4'd0;
   localparam logic [TYPE_W-1:0] REQ_PKT_BYTE   = 4'd1;
   localparam logic [TYPE_W-1:0] REQ_TX_DONE    = 4'd2;
   localparam logic [TYPE_W-1:0] REQ_DTR        = 4'd3;
   localparam logic [TYPE_W-1:0] REQ_TICK       = 4'd4;
   localparam logic [TYPE_W-1:0] REQ_CONN       = 4'd5;
   localparam logic [TYPE_W-1:0] REQ_CLR_DROPS  = 4'd6;
   localparam logic [TYPE_W-1:0] REQ_FORCE_STOP = 4'd7;
   localparam logic [TYPE_W-1:0] REQ_RING_READ  = 4'd8;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

   // Register indexes (byte address bit 2)
   localparam logic REG_AUTO_STREAM = 1'b0;
   localparam logic REG_DISC_TICKS  = 1'b1;

   // Register reset values
   localparam logic               AUTO_STREAM_RST = 1'b1;
   localparam logic [TICKS_W-1:0] DISC_TICKS_RST  = 8'd5;

   typedef struct packed {
      logic               auto_stream_enable;
      logic [TICKS_W-1:0] disconnect_ticks;
   } cfg_type;

   // Result of one item, minus the ring byte that the registered RAM read port returns
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                chunk_start;
      logic [OFFSET_W-1:0] chunk_offset;
      logic [CLEN_W-1:0]   chunk_length;
      logic                streaming_on;
      logic [DROP_W-1:0]   drops_total;
      logic                is_read;
      logic                host_lost;
      logic                link_busy;
   } result_type;

endpackage

/* rtl/trsc_ram.sv */
module trsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/trsc_csr.sv */
module trsc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [trsc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [trsc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [trsc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output trsc_pkg::cfg_type                cfg
);
   import trsc_pkg::*;

   logic               auto_ff;
   logic [TICKS_W-1:0] ticks_ff;
   logic               wr_en;
   logic               reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_ff  <= AUTO_STREAM_RST;
         ticks_ff <= DISC_TICKS_RST;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_AUTO_STREAM: auto_ff  <= csr_pwdata[0];
            REG_DISC_TICKS:  ticks_ff <= csr_pwdata[TICKS_W-1:0];
            default:         auto_ff  <= auto_ff;
         endcase
      end
   end

   // Read-back
   always_comb begin
      unique case (reg_sel)
         REG_AUTO_STREAM: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, auto_ff};
         REG_DISC_TICKS:  csr_prdata = {{(CSR_DATA_W-TICKS_W){1'b0}}, ticks_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.auto_stream_enable = auto_ff;
   assign cfg.disconnect_ticks   = ticks_ff;

endmodule

/* rtl/trsc_ctrl.sv */
module trsc_ctrl #(
   parameter int RING_BYTES = trsc_pkg::RING_BYTES_DEF,
   parameter int MAX_CHUNK  = trsc_pkg::MAX_CHUNK_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  trsc_pkg::cfg_type                  cfg,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [trsc_pkg::TYPE_W-1:0]        req_type,
   input  logic [trsc_pkg::PLEN_W-1:0]        req_packet_length,
   input  logic [trsc_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                               req_line_level,
   input  logic                               req_link_ready,
   input  logic [trsc_pkg::INDEX_W-1:0]       req_read_index,
   // pending result toward the output register
   output logic                               pend_valid,
   output trsc_pkg::result_type               pend,
   input  logic                               pend_take,
   // ring RAM
   output logic                               ram_wr_en,
   output logic [$clog2(RING_BYTES)-1:0]      ram_wr_addr,
   output logic [trsc_pkg::BYTE_W-1:0]        ram_wr_data,
   output logic                               ram_rd_en,
   output logic [$clog2(RING_BYTES)-1:0]      ram_rd_addr
);
   import trsc_pkg::*;

   localparam int PW = $clog2(RING_BYTES);
   // wide enough for the ring size, a packet length and a chunk size
   localparam int CW = (PW + 1 > PLEN_W + 1) ? PW + 1 : PLEN_W + 1;
   localparam logic [CW-1:0] RING_C = CW'(RING_BYTES);
   localparam logic [CW-1:0] MAX_C  = CW'(MAX_CHUNK);

   logic [PW-1:0]      wp_ff, wp_in;
   logic [PW-1:0]      rp_ff, rp_in;
   logic               in_flight_ff, in_flight_in;
   logic [DROP_W-1:0]  drop_ff, drop_in;
   logic [DROP_W-1:0]  snap_ff, snap_in;
   logic [TICKS_W-1:0] streak_ff, streak_in;
   logic               streaming_ff, streaming_in;
   logic [PLEN_W-1:0]  fill_rem_ff, fill_rem_in;
   logic [PW-1:0]      fill_pos_ff, fill_pos_in;
   logic               pend_valid_ff;
   result_type         pend_ff, res_in;

   logic               accept;
   logic [PW-1:0]      fill_pos_inc;
   logic [CW-1:0]      fill_pos_sum;
   logic [PW-1:0]      wp_l;
   logic               in_flight_l;
   logic               can_launch;
   logic [CW-1:0]      gap;
   logic [CW-1:0]      clen;
   logic [CW-1:0]      rp_sum;
   logic [PW-1:0]      rp_adv;
   logic [CW-1:0]      free_c;
   logic               plen_bad;
   logic               ridx_ok;
   logic               attempt;
   logic               launch_go;
   logic               we_raw;
   logic               re_raw;
   logic               lost;
   logic [STATUS_W-1:0] status;
   logic [TICKS_W-1:0] streak_tmp;

   // Handshake: one item sits in the pending stage at most
   assign req_stall  = pend_valid_ff && !pend_take;
   assign accept     = req_valid && !req_stall;
   assign pend_valid = pend_valid_ff;
   assign pend       = pend_ff;

   // Next fill position with wrap
   assign fill_pos_sum = CW'(fill_pos_ff) + CW'(1);
   assign fill_pos_inc = (fill_pos_sum == RING_C) ? '0 : PW'(fill_pos_sum);

   // Free space, one slot kept empty
   assign free_c = (wp_ff >= rp_ff) ? (RING_C - (CW'(wp_ff) - CW'(rp_ff)) - CW'(1))
                                    : (CW'(rp_ff) - CW'(wp_ff) - CW'(1));
   assign plen_bad = (req_packet_length == '0) || (CW'(req_packet_length) > RING_C);
   assign ridx_ok  = CW'(req_read_index) < RING_C;

   // Chunk sizing: up to write position or wrap point, capped at MAX_CHUNK
   assign wp_l        = (req_type == REQ_PKT_BYTE) ? fill_pos_inc : wp_ff;
   assign in_flight_l = (req_type == REQ_TX_DONE) ? 1'b0 : in_flight_ff;
   assign can_launch  = !in_flight_l && (wp_l != rp_ff);
   assign gap         = (wp_l > rp_ff) ? (CW'(wp_l) - CW'(rp_ff)) : (RING_C - CW'(rp_ff));
   assign clen        = (gap > MAX_C) ? MAX_C : gap;
   assign rp_sum      = CW'(rp_ff) + clen;
   assign rp_adv      = (rp_sum >= RING_C) ? PW'(rp_sum - RING_C) : PW'(rp_sum);
   assign launch_go   = attempt && can_launch && req_link_ready;

   // Request decode and next state
   always_comb begin
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      in_flight_in = in_flight_ff;
      drop_in      = drop_ff;
      snap_in      = snap_ff;
      streak_in    = streak_ff;
      streaming_in = streaming_ff;
      fill_rem_in  = fill_rem_ff;
      fill_pos_in  = fill_pos_ff;
      status       = ST_OK;
      attempt      = 1'b0;
      lost         = 1'b0;
      we_raw       = 1'b0;
      re_raw       = 1'b0;
      streak_tmp   = '0;

      unique case (req_type)
         REQ_PKT_START: begin
            fill_rem_in = '0;
            if (plen_bad) begin
               status = ST_BAD_LEN;
            end else if (CW'(req_packet_length) > free_c) begin
               drop_in = drop_ff + DROP_W'(1);
               status  = ST_DROPPED;
            end else begin
               fill_rem_in = req_packet_length;
               fill_pos_in = wp_ff;
            end
         end
         REQ_PKT_BYTE: begin
            if (fill_rem_ff == '0) begin
               status = ST_IGNORED;
            end else begin
               we_raw      = 1'b1;
               fill_pos_in = fill_pos_inc;
               fill_rem_in = fill_rem_ff - PLEN_W'(1);
               if (fill_rem_ff == PLEN_W'(1)) begin
                  wp_in   = fill_pos_inc;
                  attempt = 1'b1;
               end
            end
         end
         REQ_TX_DONE: begin
            in_flight_in = 1'b0;
            attempt      = 1'b1;
         end
         REQ_DTR: begin
            in_flight_in = 1'b0;
            wp_in        = '0;
            rp_in        = '0;
            fill_rem_in  = '0;
            fill_pos_in  = '0;
            streak_in    = '0;
            snap_in      = drop_ff;
            if (req_line_level) begin
               if (cfg.auto_stream_enable) begin
                  streaming_in = 1'b1;
               end
            end else begin
               streaming_in = 1'b0;
               lost         = 1'b1;
            end
         end
         REQ_TICK: begin
            if (!streaming_ff) begin
               streak_in = '0;
            end else begin
               streak_tmp = (drop_ff > snap_ff) ? streak_ff + TICKS_W'(1) : '0;
               snap_in    = drop_ff;
               if (streak_tmp >= cfg.disconnect_ticks) begin
                  streaming_in = 1'b0;
                  streak_in    = '0;
               end else begin
                  streak_in = streak_tmp;
               end
            end
         end
         REQ_CONN: begin
            if (!req_line_level) begin
               streaming_in = 1'b0;
               streak_in    = '0;
            end
         end
         REQ_CLR_DROPS: begin
            drop_in = '0;
         end
         REQ_FORCE_STOP: begin
            streaming_in = 1'b0;
         end
         REQ_RING_READ: begin
            if (ridx_ok) begin
               re_raw = 1'b1;
            end else begin
               status = ST_IGNORED;
            end
         end
         default: begin
            status = ST_IGNORED;
         end
      endcase

      // Chunk launch accepted by the link
      if (launch_go) begin
         in_flight_in = 1'b1;
         rp_in        = rp_adv;
      end

      res_in.status       = status;
      res_in.chunk_start  = launch_go;
      res_in.chunk_offset = launch_go ? OFFSET_W'(rp_ff) : '0;
      res_in.chunk_length = launch_go ? CLEN_W'(clen) : '0;
      res_in.streaming_on = streaming_in;
      res_in.drops_total  = drop_in;
      res_in.is_read      = re_raw;
      res_in.host_lost    = lost;
      res_in.link_busy    = in_flight_in;
   end

   // Ring RAM access: write a packet byte, read for a ring read
   assign ram_wr_en   = accept && we_raw;
   assign ram_wr_addr = fill_pos_ff;
   assign ram_wr_data = req_data_byte;
   assign ram_rd_en   = accept && re_raw;
   assign ram_rd_addr = PW'(req_read_index);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         rp_ff         <= '0;
         in_flight_ff  <= 1'b0;
         drop_ff       <= '0;
         snap_ff       <= '0;
         streak_ff     <= '0;
         streaming_ff  <= 1'b0;
         fill_rem_ff   <= '0;
         fill_pos_ff   <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            wp_ff        <= wp_in;
            rp_ff        <= rp_in;
            in_flight_ff <= in_flight_in;
            drop_ff      <= drop_in;
            snap_ff      <= snap_in;
            streak_ff    <= streak_in;
            streaming_ff <= streaming_in;
            fill_rem_ff  <= fill_rem_in;
            fill_pos_ff  <= fill_pos_in;
         end
         if (accept) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_take) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   // Pending result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= res_in;
      end
   end

   // Checks
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (CW'(wp_ff) < RING_C) && (CW'(rp_ff) < RING_C) && (CW'(fill_pos_ff) < RING_C))
      else $error("ring pointer beyond ring size");

   a_chunk_len: assert property (@(posedge clock) disable iff (reset)
      launch_go |-> (clen != '0) && (clen <= MAX_C))
      else $error("launched chunk length out of range");

   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(in_flight_ff) |-> $past(accept && launch_go))
      else $error("link busy without a launched chunk");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !pend_take && !accept |=> pend_valid_ff)
      else $error("pending result lost");

endmodule

/* rtl/tx_ring_streaming_controller.sv */
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// req      | req_valid / req_stall  | type, packet_length, data_byte, line_level,
//          |                        | link_ready, read_index
// rsp      | rsp_valid / rsp_stall  | status, chunk_*, streaming_on, drops_total,
//          |                        | read_byte, host_lost, link_busy
// csr      | APB psel/penable/pready| 0x0 auto_stream_enable, 0x4 disconnect_ticks
//
// One item per cycle while req_stall stays low; a result passes the pending stage
// and then the output register onto rsp, the pending stage covering the registered
// read port of the ring RAM.
// Control state resets synchronously; the ring RAM is not cleared and needs no
// clearing pass, bytes are readable once written.
// A held rsp_stall keeps the output register; one more item waits in the
// pending stage, after which req_stall rises.
module tx_ring_streaming_controller #(
   parameter int RING_BYTES = trsc_pkg::RING_BYTES_DEF,
   parameter int MAX_CHUNK  = trsc_pkg::MAX_CHUNK_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [trsc_pkg::TYPE_W-1:0]       req_type,
   input  logic [trsc_pkg::PLEN_W-1:0]       req_packet_length,
   input  logic [trsc_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              req_line_level,
   input  logic                              req_link_ready,
   input  logic [trsc_pkg::INDEX_W-1:0]      req_read_index,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [trsc_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_chunk_start,
   output logic [trsc_pkg::OFFSET_W-1:0]     rsp_chunk_offset,
   output logic [trsc_pkg::CLEN_W-1:0]       rsp_chunk_length,
   output logic                              rsp_streaming_on,
   output logic [trsc_pkg::DROP_W-1:0]       rsp_drops_total,
   output logic [trsc_pkg::BYTE_W-1:0]       rsp_read_byte,
   output logic                              rsp_host_lost,
   output logic                              rsp_link_busy,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [trsc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [trsc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [trsc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import trsc_pkg::*;

   localparam int PW = $clog2(RING_BYTES);

   cfg_type           cfg;
   result_type        pend;
   logic              pend_valid;
   logic              pend_take;
   logic              ram_wr_en;
   logic [PW-1:0]     ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [PW-1:0]     ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   logic              rsp_valid_ff;
   result_type        rsp_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;

   trsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   trsc_ctrl #(
      .RING_BYTES (RING_BYTES),
      .MAX_CHUNK  (MAX_CHUNK)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_packet_length (req_packet_length),
      .req_data_byte     (req_data_byte),
      .req_line_level    (req_line_level),
      .req_link_ready    (req_link_ready),
      .req_read_index    (req_read_index),
      .pend_valid        (pend_valid),
      .pend              (pend),
      .pend_take         (pend_take),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr)
   );

   trsc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_BYTES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Move the pending result on when the output register is free or drains
   assign pend_take = pend_valid && (!rsp_valid_ff || !rsp_stall);

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output payload; ring byte joins from the RAM read port
   always_ff @(posedge clock) begin
      if (pend_take) begin
         rsp_ff      <= pend;
         rsp_byte_ff <= pend.is_read ? ram_rd_data : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_chunk_start  = rsp_ff.chunk_start;
   assign rsp_chunk_offset = rsp_ff.chunk_offset;
   assign rsp_chunk_length = rsp_ff.chunk_length;
   assign rsp_streaming_on = rsp_ff.streaming_on;
   assign rsp_drops_total  = rsp_ff.drops_total;
   assign rsp_read_byte    = rsp_byte_ff;
   assign rsp_host_lost    = rsp_ff.host_lost;
   assign rsp_link_busy    = rsp_ff.link_busy;

endmodule

/* tb/tx_ring_streaming_controller_test.sv */
module tx_ring_streaming_controller_test;
   import trsc_pkg::*;

   localparam int CLK_PERIOD = 20;
   localparam int RING       = RING_BYTES_DEF;
   localparam int MAXC       = MAX_CHUNK_DEF;

   // request codes the block does not define
   localparam logic [TYPE_W-1:0] REQ_UNUSED_FIRST = 4'd9;
   localparam logic [TYPE_W-1:0] REQ_UNUSED_LAST  = 4'd15;

   localparam logic [CSR_ADDR_W-1:0] ADDR_AUTO  = {REG_AUTO_STREAM, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_TICKS = {REG_DISC_TICKS, 2'b00};

   typedef struct packed {
      logic [TYPE_W-1:0]  kind;
      logic [PLEN_W-1:0]  plen;
      logic [BYTE_W-1:0]  data;
      logic               level;
      logic               ready;
      logic [INDEX_W-1:0] index;
   } ring_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                chunk_start;
      logic [OFFSET_W-1:0] chunk_offset;
      logic [CLEN_W-1:0]   chunk_length;
      logic                streaming_on;
      logic [DROP_W-1:0]   drops_total;
      logic [BYTE_W-1:0]   read_byte;
      logic                host_lost;
      logic                link_busy;
   } ring_rsp_type;

   typedef struct packed {
      ring_req_type rq;
      logic         typed;
      ring_rsp_type rs;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [TYPE_W-1:0]     req_type = '0;
   logic [PLEN_W-1:0]     req_packet_length = '0;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic                  req_line_level = 1'b0;
   logic                  req_link_ready = 1'b0;
   logic [INDEX_W-1:0]    req_read_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_chunk_start;
   logic [OFFSET_W-1:0]   rsp_chunk_offset;
   logic [CLEN_W-1:0]     rsp_chunk_length;
   logic                  rsp_streaming_on;
   logic [DROP_W-1:0]     rsp_drops_total;
   logic [BYTE_W-1:0]     rsp_read_byte;
   logic                  rsp_host_lost;
   logic                  rsp_link_busy;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow of the controller state
   logic [7:0]  ring_copy [RING];
   bit          ring_known [RING];
   int          known_list [$];
   int          rp_write = 0;
   int          rp_read = 0;
   int          rp_fill_pos = 0;
   int          rp_fill_left = 0;
   bit          rp_busy = 1'b0;
   logic [31:0] rp_drops = '0;
   logic [31:0] rp_drop_mark = '0;
   logic [7:0]  rp_streak = '0;
   bit          rp_stream = 1'b0;
   bit          cfg_auto = AUTO_STREAM_RST;
   logic [7:0]  cfg_ticks = DISC_TICKS_RST;

   ring_rsp_type due_results [$];
   int          fail_count = 0;
   int          items_done = 0;
   int          chunks_seen = 0;
   int          drops_seen = 0;
   int          settings_used = 0;
   bit          idle_on = 1'b1;
   bit          hold_request = 1'b0;
   int          hold_left = 0;

   // directed rows: results typed in only where they are plain after reset
   localparam int DIR_ROWS = 26;
   dir_row_type directed [DIR_ROWS] = '{
      '{'{REQ_PKT_START, 16'd0, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b1,
        '{ST_BAD_LEN, 1'b0, 15'd0, 15'd0, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0}},
      '{'{REQ_PKT_START, 16'hFFFF, 8'h00, 1'b0, 1'b1, 15'd0}, 1'b1,
        '{ST_BAD_LEN, 1'b0, 15'd0, 15'd0, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0}},
      '{'{REQ_PKT_START, 16'h8000, 8'h00, 1'b0, 1'b1, 15'd0}, 1'b1,
        '{ST_DROPPED, 1'b0, 15'd0, 15'd0, 1'b0, 32'd1, 8'd0, 1'b0, 1'b0}},
      '{'{REQ_PKT_BYTE, 16'd0, 8'hFF, 1'b1, 1'b1, 15'd0}, 1'b1,
        '{ST_IGNORED, 1'b0, 15'd0, 15'd0, 1'b0, 32'd1, 8'd0, 1'b0, 1'b0}},
      '{'{REQ_UNUSED_LAST, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 15'h7FFF}, 1'b1,
        '{ST_IGNORED, 1'b0, 15'd0, 15'd0, 1'b0, 32'd1, 8'd0, 1'b0, 1'b0}},
      '{'{REQ_DTR, 16'd0, 8'h00, 1'b1, 1'b0, 15'd0}, 1'b1,
        '{ST_OK, 1'b0, 15'd0, 15'd0, 1'b1, 32'd1, 8'd0, 1'b0, 1'b0}},
      '{'{REQ_PKT_START, 16'd3, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_PKT_BYTE, 16'd0, 8'h00, 1'b0, 1'b1, 15'd0}, 1'b0, '0},
      '{'{REQ_PKT_BYTE, 16'd0, 8'hFF, 1'b0, 1'b1, 15'd0}, 1'b0, '0},
      '{'{REQ_PKT_BYTE, 16'd0, 8'hA5, 1'b0, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_TX_DONE, 16'd0, 8'h00, 1'b0, 1'b1, 15'd0}, 1'b0, '0},
      '{'{REQ_PKT_START, 16'd2, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_PKT_BYTE, 16'd0, 8'h5A, 1'b0, 1'b1, 15'd0}, 1'b0, '0},
      '{'{REQ_PKT_START, 16'd1, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_PKT_BYTE, 16'd0, 8'hC3, 1'b0, 1'b1, 15'd0}, 1'b0, '0},
      '{'{REQ_TX_DONE, 16'd0, 8'h00, 1'b0, 1'b1, 15'd0}, 1'b0, '0},
      '{'{REQ_RING_READ, 16'd0, 8'h00, 1'b0, 1'b0, 15'd1}, 1'b0, '0},
      '{'{REQ_TICK, 16'd0, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_PKT_START, 16'h8000, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_TICK, 16'd0, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_CONN, 16'd0, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_DTR, 16'd0, 8'h00, 1'b1, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_FORCE_STOP, 16'd0, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_CLR_DROPS, 16'd0, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b0, '0},
      '{'{REQ_DTR, 16'd0, 8'h00, 1'b0, 1'b1, 15'd0}, 1'b0, '0},
      '{'{REQ_TX_DONE, 16'd0, 8'h00, 1'b0, 1'b0, 15'd0}, 1'b0, '0}
   };

   tx_ring_streaming_controller i_dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // free bytes, one slot always kept empty
   function automatic int ring_free();
      return (rp_write >= rp_read) ? RING - (rp_write - rp_read) - 1 : rp_read - rp_write - 1;
   endfunction

   // launch one chunk from the read position if the link takes it
   function automatic void launch_chunk(input bit accept, inout ring_rsp_type rs);
      int span;
      if (rp_busy || rp_write == rp_read) return;
      span = (rp_write > rp_read) ? rp_write - rp_read : RING - rp_read;
      if (span > MAXC) span = MAXC;
      if (!accept) return;
      rp_busy         = 1'b1;
      rs.chunk_start  = 1'b1;
      rs.chunk_offset = OFFSET_W'(rp_read);
      rs.chunk_length = CLEN_W'(span);
      rp_read         = (rp_read + span) % RING;
   endfunction

   // next result of the controller for one request
   function automatic void tx_ring_step(input ring_req_type rq, output ring_rsp_type rs);
      rs = '0;
      case (rq.kind)
         REQ_PKT_START: begin
            rp_fill_left = 0;
            if (rq.plen == 0 || int'(rq.plen) > RING) begin
               rs.status = ST_BAD_LEN;
            end else if (int'(rq.plen) > ring_free()) begin
               rp_drops  = rp_drops + 32'd1;
               rs.status = ST_DROPPED;
            end else begin
               rp_fill_left = rq.plen;
               rp_fill_pos  = rp_write;
            end
         end
         REQ_PKT_BYTE: begin
            if (rp_fill_left == 0) begin
               rs.status = ST_IGNORED;
            end else begin
               ring_copy[rp_fill_pos] = rq.data;
               if (!ring_known[rp_fill_pos]) begin
                  ring_known[rp_fill_pos] = 1'b1;
                  known_list.push_back(rp_fill_pos);
               end
               rp_fill_pos = (rp_fill_pos + 1) % RING;
               rp_fill_left--;
               if (rp_fill_left == 0) begin
                  rp_write = rp_fill_pos;
                  launch_chunk(rq.ready, rs);
               end
            end
         end
         REQ_TX_DONE: begin
            rp_busy = 1'b0;
            launch_chunk(rq.ready, rs);
         end
         REQ_DTR: begin
            rp_busy      = 1'b0;
            rp_write     = 0;
            rp_read      = 0;
            rp_fill_left = 0;
            rp_fill_pos  = 0;
            rp_streak    = '0;
            rp_drop_mark = rp_drops;
            if (rq.level) begin
               if (cfg_auto) rp_stream = 1'b1;
            end else begin
               rp_stream    = 1'b0;
               rs.host_lost = 1'b1;
            end
         end
         REQ_TICK: begin
            if (!rp_stream) begin
               rp_streak = '0;
            end else begin
               // unsigned compare: the tick where the counter wraps does not count
               rp_streak    = (rp_drops > rp_drop_mark) ? rp_streak + 8'd1 : 8'd0;
               rp_drop_mark = rp_drops;
               if (rp_streak >= cfg_ticks) begin
                  rp_stream = 1'b0;
                  rp_streak = '0;
               end
            end
         end
         REQ_CONN: begin
            if (!rq.level) begin
               rp_stream = 1'b0;
               rp_streak = '0;
            end
         end
         REQ_CLR_DROPS:  rp_drops = '0;
         REQ_FORCE_STOP: rp_stream = 1'b0;
         REQ_RING_READ: begin
            if (int'(rq.index) < RING) rs.read_byte = ring_copy[rq.index];
            else rs.status = ST_IGNORED;
         end
         default: rs.status = ST_IGNORED;
      endcase
      rs.streaming_on = rp_stream;
      rs.drops_total  = rp_drops;
      rs.link_busy    = rp_busy;
   endfunction

   // request with random content; ring reads only hit written entries when there are any
   function automatic ring_req_type noise_req(input logic [TYPE_W-1:0] kind);
      ring_req_type rq;
      rq.kind  = kind;
      rq.plen  = PLEN_W'($urandom);
      rq.data  = BYTE_W'($urandom);
      rq.level = 1'($urandom);
      rq.ready = 1'($urandom);
      rq.index = INDEX_W'($urandom);
      if (kind == REQ_RING_READ && known_list.size() > 0)
         rq.index = INDEX_W'(known_list[$urandom_range(known_list.size() - 1)]);
      return rq;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // one request transfer; the expected result is queued when it is taken
   task automatic offer(input ring_req_type rq, output ring_rsp_type want,
                        input bit typed_row = 1'b0, input ring_rsp_type typed = '0);
      while (idle_on && $urandom_range(99) < 28) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_type          <= rq.kind;
      req_packet_length <= rq.plen;
      req_data_byte     <= rq.data;
      req_line_level    <= rq.level;
      req_link_ready    <= rq.ready;
      req_read_index    <= rq.index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tx_ring_step(rq, want);
      due_results.push_back(typed_row ? typed : want);
      if (want.status != ST_IGNORED) items_done++;
      if (want.status == ST_DROPPED) drops_seen++;
      if (want.chunk_start) chunks_seen++;
   endtask

   // start plus the first cut bytes, with optional side requests in between
   task automatic send_packet(input int len, input int cut, input int ready_pct,
                              input int noise_pct, output bit taken);
      ring_req_type rq;
      ring_rsp_type want;
      rq      = noise_req(REQ_PKT_START);
      rq.plen = PLEN_W'(len);
      offer(rq, want);
      taken = (want.status == ST_OK);
      if (taken) begin
         for (int i = 0; i < cut; i++) begin
            if ($urandom_range(99) < noise_pct) begin
               rq = noise_req($urandom_range(1) ? REQ_TX_DONE : REQ_TICK);
               offer(rq, want);
            end
            rq       = noise_req(REQ_PKT_BYTE);
            rq.ready = ($urandom_range(99) < ready_pct);
            offer(rq, want);
         end
      end
   endtask

   // pause until every result is back, plus the pipeline depth
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, then read back
   task automatic set_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      check_field("register readback", value, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(input bit auto_on, input logic [7:0] ticks);
      set_reg(ADDR_AUTO, CSR_DATA_W'(auto_on));
      cfg_auto = auto_on;
      set_reg(ADDR_TICKS, CSR_DATA_W'(ticks));
      cfg_ticks = ticks;
      settings_used++;
   endtask

   // mixed traffic, mostly packets, until count more requests were taken and not ignored
   task automatic random_traffic(input int count);
      int           stop;
      int           pick;
      int           plen;
      bit           taken;
      ring_req_type rq;
      ring_rsp_type want;
      stop = items_done + count;
      while (items_done < stop) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            plen = ($urandom_range(29) == 0) ? $urandom_range(120, 40) : $urandom_range(12, 1);
            send_packet(plen, ($urandom_range(9) == 0) ? $urandom_range(plen - 1) : plen,
                        80, 5, taken);
         end else if (pick < 60) begin
            rq       = noise_req(REQ_TX_DONE);
            rq.ready = ($urandom_range(4) != 0);
            offer(rq, want);
         end else if (pick < 70) begin
            // drops on consecutive ticks wear down the streaming flag
            repeat ($urandom_range(6, 1)) begin
               rq      = noise_req(REQ_PKT_START);
               rq.plen = PLEN_W'($urandom_range(RING, ring_free() + 1));
               offer(rq, want);
               rq = noise_req(REQ_TICK);
               offer(rq, want);
            end
         end else if (pick < 74) begin
            rq       = noise_req(REQ_DTR);
            rq.level = ($urandom_range(3) != 0);
            offer(rq, want);
         end else if (pick < 77) begin
            offer(noise_req(REQ_CONN), want);
         end else if (pick < 80) begin
            offer(noise_req(REQ_TICK), want);
         end else if (pick < 82) begin
            offer(noise_req(REQ_CLR_DROPS), want);
         end else if (pick < 84) begin
            offer(noise_req(REQ_FORCE_STOP), want);
         end else if (pick < 92) begin
            if (known_list.size() > 0) offer(noise_req(REQ_RING_READ), want);
         end else if (pick < 95) begin
            rq      = noise_req(REQ_PKT_START);
            rq.plen = $urandom_range(1) ? PLEN_W'(0) : PLEN_W'($urandom_range(65535, RING + 1));
            offer(rq, want);
         end else if (pick < 97) begin
            offer(noise_req(REQ_PKT_BYTE), want);
         end else begin
            offer(noise_req(TYPE_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST))), want);
         end
      end
   endtask

   // result side: random stall, long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = 80;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 28);
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : result_check
      ring_rsp_type head;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: result transfer with nothing expected", $time);
            fail_count++;
         end else begin
            head = due_results.pop_front();
            check_field("status", head.status, rsp_status);
            check_field("chunk_start", head.chunk_start, rsp_chunk_start);
            check_field("chunk_offset", head.chunk_offset, rsp_chunk_offset);
            check_field("chunk_length", head.chunk_length, rsp_chunk_length);
            check_field("streaming_on", head.streaming_on, rsp_streaming_on);
            check_field("drops_total", head.drops_total, rsp_drops_total);
            check_field("read_byte", head.read_byte, rsp_read_byte);
            check_field("host_lost", head.host_lost, rsp_host_lost);
            check_field("link_busy", head.link_busy, rsp_link_busy);
         end
      end
   end

   initial begin : watchdog
      #(CLK_PERIOD * 1500000);
      $display("tx_ring_streaming_controller_test NOT OK");
      $finish;
   end

   initial begin : stimulus
      ring_rsp_type want;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) offer(directed[i].rq, want, directed[i].typed, directed[i].rs);
      drain();

      random_traffic(120);
      drain();

      // output held off long enough to back up the input
      set_config(1'b1, 8'd1);
      hold_request = 1'b1;
      random_traffic(100);
      drain();

      set_config(1'b0, 8'd255);
      random_traffic(80);
      drain();

      set_config(1'b1, 8'd0);
      random_traffic(80);
      drain();

      // no idling on either side, with one more hold-off
      set_config(1'b1, 8'd2);
      idle_on      = 1'b0;
      hold_request = 1'b1;
      random_traffic(150);
      drain();
      idle_on = 1'b1;

      set_config(1'b1, 8'd5);
      random_traffic(70);
      drain();
      repeat (8) @(posedge clock);

      $display("Covered %0d requests over %0d register settings, %0d chunks launched.",
               items_done, settings_used, chunks_seen);
      $display("Saw %0d packets dropped for lack of room, with input backed up twice.",
               drops_seen);
      if (fail_count == 0) begin
         $display("tx_ring_streaming_controller_test OK");
      end else begin
         $display("tx_ring_streaming_controller_test NOT OK");
      end
      $finish;
   end

endmodule

/* tx_ring_streaming_controller.f */
rtl/trsc_pkg.sv
rtl/trsc_ram.sv
rtl/trsc_csr.sv
rtl/trsc_ctrl.sv
rtl/tx_ring_streaming_controller.sv
tb/tx_ring_streaming_controller_test.sv
